// ----- rtl/stim_pkg.sv -----
`default_nettype none

package stim_pkg;

    // parameter defaults
    localparam int PRINT_TIMES_DEF      = 32;
    localparam int MAX_OBSERVATIONS_DEF = 1048576;

    // command queue depth between front and back
    localparam int QUEUE_DEPTH = 4;

    // reset value of the print time count register
    localparam logic [5:0] PRINT_COUNT_RST = 6'd32;

    // input mode codes
    localparam logic [1:0] MODE_LOAD = 2'd0;
    localparam logic [1:0] MODE_OBS  = 2'd1;
    localparam logic [1:0] MODE_RUN  = 2'd2;

    // classified command kinds
    localparam logic [1:0] KIND_LOAD = 2'd0;
    localparam logic [1:0] KIND_OBS  = 2'd1;
    localparam logic [1:0] KIND_RUN  = 2'd2;

    // tie codes
    localparam logic [1:0] TIE_PREV  = 2'd0;
    localparam logic [1:0] TIE_FIRST = 2'd1;
    localparam logic [1:0] TIE_EXACT = 2'd2;

    typedef struct packed {
        logic [1:0]         mode;
        logic [4:0]         slot;
        logic [31:0]        time_value;
        logic signed [31:0] stratum_id;
    } t_in_word;

    typedef struct packed {
        logic [15:0] stratum_ordinal;
        logic [4:0]  print_slot;
        logic [20:0] obs_index;
        logic [1:0]  tie_code;
        logic        last;
    } t_out_word;

    typedef struct packed {
        logic [1:0]  kind;
        logic [4:0]  slot;
        logic [31:0] time_value;
        logic [31:0] stratum_id;
    } t_cmd;

endpackage

`default_nettype wire

// ----- rtl/stim_front.sv -----
`default_nettype none

module stim_front import stim_pkg::*; #(
    parameter int PRINT_TIMES = PRINT_TIMES_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_ready,
    input  wire t_in_word i_data,
    output logic          o_q_valid,
    output t_cmd          o_q_cmd,
    input  wire logic     i_q_pop
);

    localparam int QPW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_queue [QUEUE_DEPTH];
    logic [QPW-1:0]   r_wr_ptr;
    logic [QPW-1:0]   r_rd_ptr;
    logic [QCW-1:0]   r_count;

    logic             w_accept;
    logic             w_keep;
    logic             w_slot_ok;
    logic             w_push;
    logic             w_pop;
    t_cmd             w_cmd;

    // classify: unused mode and out-of-range loads are dropped here
    assign w_accept  = i_valid && o_ready;
    assign w_slot_ok = 7'(i_data.slot) < 7'(PRINT_TIMES);
    always_comb begin
        case (i_data.mode)
            MODE_LOAD: w_keep = w_slot_ok;
            MODE_OBS:  w_keep = 1'b1;
            MODE_RUN:  w_keep = 1'b1;
            default:   w_keep = 1'b0;
        endcase
    end

    always_comb begin
        w_cmd.kind       = i_data.mode;
        w_cmd.slot       = i_data.slot;
        w_cmd.time_value = i_data.time_value;
        w_cmd.stratum_id = i_data.stratum_id;
    end

    assign w_push    = w_accept && w_keep;
    assign w_pop     = i_q_pop && o_q_valid;
    assign o_ready   = r_count != QCW'(QUEUE_DEPTH);
    assign o_q_valid = r_count != '0;
    assign o_q_cmd   = r_queue[r_rd_ptr];

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_queue[r_wr_ptr] <= w_cmd;
        end
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == QPW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCW'(QUEUE_DEPTH))
        else $error("queue count overflow");
    a_full_no_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == QCW'(QUEUE_DEPTH) && !w_pop) |=> r_count == QCW'(QUEUE_DEPTH))
        else $error("full queue changed without pop");
    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_wr_ptr == r_rd_ptr))
        else $error("empty queue with pointers apart");
`endif

endmodule

`default_nettype wire

// ----- rtl/stim_back.sv -----
`default_nettype none

module stim_back import stim_pkg::*; #(
    parameter int PRINT_TIMES      = PRINT_TIMES_DEF,
    parameter int MAX_OBSERVATIONS = MAX_OBSERVATIONS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic [5:0] i_print_count,
    input  wire logic       i_q_valid,
    input  wire t_cmd       i_q_cmd,
    output logic            o_q_pop,
    output logic            o_valid,
    input  wire logic       i_ready,
    output t_out_word       o_data
);

    localparam int IW = (PRINT_TIMES > 1) ? $clog2(PRINT_TIMES) : 1;
    localparam int PW = $clog2(PRINT_TIMES + 1);
    localparam int OW = $clog2(MAX_OBSERVATIONS);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_WALK = 1'b1;

    logic [31:0]    r_table [PRINT_TIMES];
    logic           r_state;
    logic [PW-1:0]  r_nps;
    logic [31:0]    r_prev;
    logic           r_hasp;
    logic [31:0]    r_cur;
    logic [15:0]    r_scnt;
    logic [OW-1:0]  r_obs;
    logic           r_started;
    logic [31:0]    r_t;
    logic           r_hold_v;
    t_out_word      r_hold;
    logic           r_out_v;
    t_out_word      r_out;

    logic [6:0]     w_lim;
    logic [31:0]    w_p;
    logic           w_step;
    logic           w_emit;
    logic           w_can;
    logic           w_out_free;
    logic           w_pop;
    logic [IW-1:0]  w_wr_idx;
    logic [20:0]    w_idx_cur;
    logic [20:0]    w_idx_nxt;
    t_out_word      w_new;
    t_out_word      w_fin;

    assign w_out_free = !r_out_v || i_ready;
    assign w_pop      = (r_state == S_IDLE) && i_q_valid;
    assign o_q_pop    = w_pop;
    assign w_wr_idx   = IW'(i_q_cmd.slot);

    // walk limit, clamped to the table size
    assign w_lim = (7'(i_print_count) > 7'(PRINT_TIMES)) ? 7'(PRINT_TIMES)
                                                         : 7'(i_print_count);

    // one print time examined per cycle unless a result waits on a stalled output
    assign w_p    = r_table[r_nps[IW-1:0]];
    assign w_step = (7'(r_nps) < w_lim) && (w_p <= r_t);
    assign w_emit = w_step && (!r_hasp || r_prev < w_p);
    assign w_can  = !r_hold_v || w_out_free;

    assign w_idx_cur = 21'(r_obs);
    assign w_idx_nxt = 21'({1'b0, r_obs} + 1'b1);

    // result built for the current slot
    always_comb begin
        w_new.stratum_ordinal = r_scnt;
        w_new.print_slot      = 5'(r_nps);
        w_new.last            = 1'b0;
        if (w_p < r_t) begin
            if (r_hasp && r_prev != '0) begin
                w_new.obs_index = w_idx_cur;
                w_new.tie_code  = TIE_PREV;
            end else begin
                w_new.obs_index = w_idx_nxt;
                w_new.tie_code  = TIE_FIRST;
            end
        end else begin
            w_new.obs_index = w_idx_nxt;
            w_new.tie_code  = TIE_EXACT;
        end
    end

    // held result with its last flag settled
    always_comb begin
        w_fin      = r_hold;
        w_fin.last = !w_step;
    end

    // print time table writes
    always_ff @(posedge i_clk) begin
        if (w_pop && i_q_cmd.kind == KIND_LOAD) begin
            r_table[w_wr_idx] <= i_q_cmd.time_value;
        end
    end

    // observation time latch
    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_t <= i_q_cmd.time_value;
        end
    end

    // sequencer and walk state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_nps     <= '0;
            r_prev    <= '0;
            r_hasp    <= 1'b0;
            r_cur     <= '0;
            r_scnt    <= '0;
            r_obs     <= '0;
            r_started <= 1'b0;
            r_hold_v  <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_pop) begin
                        case (i_q_cmd.kind)
                            KIND_RUN: begin
                                r_nps     <= '0;
                                r_prev    <= '0;
                                r_hasp    <= 1'b0;
                                r_cur     <= '0;
                                r_scnt    <= '0;
                                r_obs     <= '0;
                                r_started <= 1'b0;
                            end
                            KIND_OBS: begin
                                r_state <= S_WALK;
                                if (!r_started) begin
                                    r_started <= 1'b1;
                                    r_cur     <= i_q_cmd.stratum_id;
                                end else if (i_q_cmd.stratum_id != r_cur) begin
                                    r_cur  <= i_q_cmd.stratum_id;
                                    r_hasp <= 1'b0;
                                    r_prev <= '0;
                                    r_nps  <= '0;
                                    if (r_scnt != 16'hFFFF) begin
                                        r_scnt <= r_scnt + 1'b1;
                                    end
                                end
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_WALK: begin
                    if (w_step) begin
                        if (!w_emit || w_can) begin
                            r_nps <= r_nps + 1'b1;
                        end
                        if (w_emit && w_can) begin
                            r_hold   <= w_new;
                            r_hold_v <= 1'b1;
                        end
                    end else if (w_can) begin
                        // walk done: close out this observation
                        r_hold_v <= 1'b0;
                        r_prev   <= r_t;
                        r_hasp   <= 1'b1;
                        if (r_obs != OW'(MAX_OBSERVATIONS - 1)) begin
                            r_obs <= r_obs + 1'b1;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // output register: held result moves out when the next one shows up
    // or when the walk ends (then it is the last one)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (r_state == S_WALK && r_hold_v && w_can &&
                     (w_emit || !w_step)) begin
            r_out_v <= 1'b1;
            r_out   <= w_fin;
        end else if (i_ready) begin
            r_out_v <= 1'b0;
        end
    end

    assign o_valid = r_out_v;
    assign o_data  = r_out;

`ifndef SYNTHESIS
    a_hold_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hold_v |-> r_state == S_WALK)
        else $error("held result outside walk");
    a_nps_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        7'(r_nps) <= 7'(PRINT_TIMES))
        else $error("print slot pointer out of range");
    a_out_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && !i_ready) |=> (r_out_v && $stable(r_out)))
        else $error("output word overwritten while stalled");
`endif

endmodule

`default_nettype wire

// ----- rtl/stratified_time_index_merge.sv -----
// Stratified print-time index merge.
// Input channel (i_valid / o_ready, i_data): mode 0 writes a print time into
// the table, mode 1 is an observation, mode 2 starts a new run, mode 3 is
// dropped. Words pass through a four-entry queue to the back end, so the
// input keeps accepting while results wait.
// Output channel (o_valid / i_ready, o_data): one word per print time passed
// above the previous observation's time in the stratum; last marks its final word.
// A word is registered into the queue and is popped by the back end while it
// is idle. An observation then walks one table slot per cycle while the output
// is not stalled, then closes; the back end pops no new word until it has
// closed. Results pass through a one-word hold stage that settles the last
// flag, then through the output register.
// Loads and run starts leave the back end idle and ready for the next word.
// i_cfg_we / i_cfg_data set the print time count; write only while idle.
// Reset (i_rst_n low, synchronous) clears run state and the queue, and sets
// the count to 32; the table stays unwritten. When the receiver stalls, the
// walk halts on its next result and the queue fills, then o_ready drops.
`default_nettype none

module stratified_time_index_merge import stim_pkg::*; #(
    parameter int PRINT_TIMES      = PRINT_TIMES_DEF,
    parameter int MAX_OBSERVATIONS = MAX_OBSERVATIONS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire t_in_word   i_data,
    output logic            o_valid,
    input  wire logic       i_ready,
    output t_out_word       o_data,
    input  wire logic       i_cfg_we,
    input  wire logic [5:0] i_cfg_data
);

    logic [5:0] r_print_count;
    logic       w_q_valid;
    logic       w_q_pop;
    t_cmd       w_q_cmd;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_print_count <= PRINT_COUNT_RST;
        end else if (i_cfg_we) begin
            r_print_count <= i_cfg_data;
        end
    end

    stim_front #(
        .PRINT_TIMES (PRINT_TIMES)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_data    (i_data),
        .o_q_valid (w_q_valid),
        .o_q_cmd   (w_q_cmd),
        .i_q_pop   (w_q_pop)
    );

    stim_back #(
        .PRINT_TIMES      (PRINT_TIMES),
        .MAX_OBSERVATIONS (MAX_OBSERVATIONS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_print_count (r_print_count),
        .i_q_valid     (w_q_valid),
        .i_q_cmd       (w_q_cmd),
        .o_q_pop       (w_q_pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_data        (o_data)
    );

endmodule

`default_nettype wire
